// ===== rtl/pshp_pkg.sv =====
package pshp_pkg;

   localparam int WINDOW_SIZE_DEF = 16384;
   localparam int COUNT_BITS_DEF  = 32;

   localparam int CMD_W   = 2;
   localparam int ADDR_W  = 64;
   localparam int RIDX_W  = 14;
   localparam int BIN_W   = 32;

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic eval;
      logic step_clear;
      logic clr_wr;
      logic pc_rd;
      logic pc_wr;
      logic ip_rd;
      logic ip_wr;
      logic mark_wr;
      logic load_rsp;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             win_ok;
      logic             ip_ok;
      logic             mark_hit;
      logic             clear_last;
   } sts_type;

endpackage

// ===== rtl/pshp_datapath.sv =====
module pshp_datapath #(
   parameter int WINDOW_SIZE = pshp_pkg::WINDOW_SIZE_DEF,
   parameter int COUNT_BITS  = pshp_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pshp_pkg::ctl_type             ctl,
   output pshp_pkg::sts_type             sts,
   input  logic [pshp_pkg::CMD_W-1:0]    req_command,
   input  logic [pshp_pkg::ADDR_W-1:0]   req_sample_pc,
   input  logic [pshp_pkg::ADDR_W-1:0]   req_sample_ip,
   input  logic [pshp_pkg::ADDR_W-1:0]   req_mark_address,
   input  logic [pshp_pkg::RIDX_W-1:0]   req_read_index,
   input  logic                          csr_write_enable,
   input  logic [pshp_pkg::ADDR_W-1:0]   csr_write_data,
   output logic [pshp_pkg::ADDR_W-1:0]   rsp_pc_low,
   output logic [pshp_pkg::ADDR_W-1:0]   rsp_pc_high,
   output logic [pshp_pkg::ADDR_W-1:0]   rsp_ip_low,
   output logic [pshp_pkg::ADDR_W-1:0]   rsp_ip_high,
   output logic [pshp_pkg::BIN_W-1:0]    rsp_bin_pc_count,
   output logic [pshp_pkg::BIN_W-1:0]    rsp_bin_ip_count,
   output logic                          rsp_bin_marked
);
   import pshp_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_SIZE);
   localparam logic [ADDR_W-1:0] WinSize = ADDR_W'(WINDOW_SIZE);
   localparam logic [IDX_W-1:0]  LastIdx = IDX_W'(WINDOW_SIZE - 1);

   // histogram and mark stores
   logic [COUNT_BITS-1:0] pc_mem [WINDOW_SIZE];
   logic [COUNT_BITS-1:0] ip_mem [WINDOW_SIZE];
   logic                  mark_mem [WINDOW_SIZE];

   logic [ADDR_W-1:0]     code_base_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic [ADDR_W-1:0]     pc_ff;
   logic [ADDR_W-1:0]     ip_ff;
   logic [ADDR_W-1:0]     mark_ff;
   logic [RIDX_W-1:0]     ridx_ff;

   logic [ADDR_W-1:0]     pc_min_ff;
   logic [ADDR_W-1:0]     pc_max_ff;
   logic [ADDR_W-1:0]     ip_min_ff;
   logic [ADDR_W-1:0]     ip_max_ff;

   logic [IDX_W-1:0]      addr_ff;
   logic [IDX_W-1:0]      ip_addr_ff;
   logic                  win_ok_ff;
   logic                  ip_ok_ff;
   logic                  ridx_ok_ff;

   logic [COUNT_BITS-1:0] pc_q_ff;
   logic [COUNT_BITS-1:0] ip_q_ff;
   logic                  mk_q_ff;

   logic [ADDR_W-1:0]     rsp_pc_low_ff;
   logic [ADDR_W-1:0]     rsp_pc_high_ff;
   logic [ADDR_W-1:0]     rsp_ip_low_ff;
   logic [ADDR_W-1:0]     rsp_ip_high_ff;
   logic [BIN_W-1:0]      rsp_bin_pc_ff;
   logic [BIN_W-1:0]      rsp_bin_ip_ff;
   logic                  rsp_bin_mk_ff;

   logic [ADDR_W-1:0]     off_src;
   logic [ADDR_W-1:0]     off_full;
   logic                  off_ok;
   logic [ADDR_W-1:0]     ip_full;
   logic                  ip_ok;
   logic                  ridx_ok;
   logic [COUNT_BITS-1:0] pc_wdata;
   logic [COUNT_BITS-1:0] ip_wdata;
   logic                  mk_wdata;
   logic [ADDR_W-1:0]     pc_q_wide;
   logic [ADDR_W-1:0]     ip_q_wide;
   logic [BIN_W-1:0]      pc_q_clamp;
   logic [BIN_W-1:0]      ip_q_clamp;
   logic                  bin_sel;

   // window offsets; mark address and sample pc share one subtractor
   always_comb begin
      off_src  = (cmd_ff == CMD_MARK) ? mark_ff : pc_ff;
      off_full = off_src - code_base_ff;
      off_ok   = (off_src >= code_base_ff) && (off_full < WinSize);
      ip_full  = ip_ff - code_base_ff;
      ip_ok    = (ip_ff > code_base_ff) && (ip_full < WinSize);
      ridx_ok  = ADDR_W'(ridx_ff) < WinSize;
   end

   // saturating increment, zero during the clearing pass
   always_comb begin
      pc_wdata = '0;
      ip_wdata = '0;
      mk_wdata = 1'b0;
      if (!ctl.clr_wr) begin
         pc_wdata = (pc_q_ff == '1) ? pc_q_ff : pc_q_ff + COUNT_BITS'(1);
         ip_wdata = (ip_q_ff == '1) ? ip_q_ff : ip_q_ff + COUNT_BITS'(1);
         mk_wdata = 1'b1;
      end
   end

   // clamp wide counts to the bin field
   always_comb begin
      pc_q_wide  = ADDR_W'(pc_q_ff);
      ip_q_wide  = ADDR_W'(ip_q_ff);
      pc_q_clamp = (pc_q_wide > ADDR_W'(64'hFFFF_FFFF)) ? '1 : pc_q_wide[BIN_W-1:0];
      ip_q_clamp = (ip_q_wide > ADDR_W'(64'hFFFF_FFFF)) ? '1 : ip_q_wide[BIN_W-1:0];
      bin_sel    = (cmd_ff == CMD_READ) && ridx_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_base_ff <= '0;
      end else if (csr_write_enable) begin
         code_base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff  <= req_command;
         pc_ff   <= req_sample_pc;
         ip_ff   <= req_sample_ip;
         mark_ff <= req_mark_address;
         ridx_ff <= req_read_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_min_ff <= '1;
         pc_max_ff <= '0;
         ip_min_ff <= '1;
         ip_max_ff <= '0;
      end else if (ctl.eval && (cmd_ff == CMD_SAMPLE)) begin
         if (pc_ff < pc_min_ff) begin
            pc_min_ff <= pc_ff;
         end
         if (pc_ff > pc_max_ff) begin
            pc_max_ff <= pc_ff;
         end
         if (ip_ff < ip_min_ff) begin
            ip_min_ff <= ip_ff;
         end
         if (ip_ff > ip_max_ff) begin
            ip_max_ff <= ip_ff;
         end
      end
   end

   // addresses sweep the stores after reset, then follow each item
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         ip_addr_ff <= '0;
      end else if (ctl.step_clear) begin
         addr_ff    <= addr_ff + IDX_W'(1);
         ip_addr_ff <= ip_addr_ff + IDX_W'(1);
      end else if (ctl.eval) begin
         if (cmd_ff == CMD_READ) begin
            addr_ff    <= IDX_W'(ridx_ff);
            ip_addr_ff <= IDX_W'(ridx_ff);
         end else begin
            addr_ff    <= off_full[IDX_W-1:0];
            ip_addr_ff <= ip_full[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.eval) begin
         win_ok_ff  <= off_ok;
         ip_ok_ff   <= ip_ok;
         ridx_ok_ff <= ridx_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_wr || ctl.pc_wr) begin
         pc_mem[addr_ff] <= pc_wdata;
      end
      if (ctl.pc_rd) begin
         pc_q_ff <= pc_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_wr || ctl.mark_wr) begin
         mark_mem[addr_ff] <= mk_wdata;
      end
      if (ctl.pc_rd) begin
         mk_q_ff <= mark_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_wr || ctl.ip_wr) begin
         ip_mem[ip_addr_ff] <= ip_wdata;
      end
      if (ctl.ip_rd) begin
         ip_q_ff <= ip_mem[ip_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_pc_low_ff  <= pc_min_ff;
         rsp_pc_high_ff <= pc_max_ff;
         rsp_ip_low_ff  <= ip_min_ff;
         rsp_ip_high_ff <= ip_max_ff;
         rsp_bin_pc_ff  <= bin_sel ? pc_q_clamp : '0;
         rsp_bin_ip_ff  <= bin_sel ? ip_q_clamp : '0;
         rsp_bin_mk_ff  <= bin_sel & mk_q_ff;
      end
   end

   always_comb begin
      sts.cmd        = cmd_ff;
      sts.win_ok     = win_ok_ff;
      sts.ip_ok      = ip_ok_ff;
      sts.mark_hit   = mk_q_ff;
      sts.clear_last = (addr_ff == LastIdx);
   end

   assign rsp_pc_low       = rsp_pc_low_ff;
   assign rsp_pc_high      = rsp_pc_high_ff;
   assign rsp_ip_low       = rsp_ip_low_ff;
   assign rsp_ip_high      = rsp_ip_high_ff;
   assign rsp_bin_pc_count = rsp_bin_pc_ff;
   assign rsp_bin_ip_count = rsp_bin_ip_ff;
   assign rsp_bin_marked   = rsp_bin_mk_ff;

endmodule

// ===== rtl/pshp_ctrl.sv =====
module pshp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pshp_pkg::sts_type sts,
   output pshp_pkg::ctl_type ctl
);
   import pshp_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_PC_RD,
      ST_PC_WR,
      ST_IP_RD,
      ST_IP_WR,
      ST_MARK_WR,
      ST_BIN_RD,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      ctl          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr_wr     = 1'b1;
            ctl.step_clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load_item = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ctl.eval = 1'b1;
            unique case (sts.cmd)
               CMD_SAMPLE: state_in = ST_PC_RD;
               CMD_MARK:   state_in = ST_MARK_WR;
               CMD_READ:   state_in = ST_BIN_RD;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_PC_RD: begin
            // out-of-window samples only touch min/max
            if (sts.win_ok) begin
               ctl.pc_rd = 1'b1;
               state_in  = ST_PC_WR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PC_WR: begin
            ctl.pc_wr = 1'b1;
            if (sts.mark_hit && sts.ip_ok) begin
               state_in = ST_IP_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_IP_RD: begin
            ctl.ip_rd = 1'b1;
            state_in  = ST_IP_WR;
         end
         ST_IP_WR: begin
            ctl.ip_wr = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_MARK_WR: begin
            ctl.mark_wr = sts.win_ok;
            state_in    = ST_FINISH;
         end
         ST_BIN_RD: begin
            ctl.pc_rd = 1'b1;
            ctl.ip_rd = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("item accepted during clearing pass");

   a_rsp_reg_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.pc_wr, ctl.ip_wr, ctl.mark_wr, ctl.load_item, ctl.load_rsp}))
      else $error("conflicting datapath commands");

   a_ip_rmw: assert property (@(posedge clock) disable iff (reset)
      ctl.ip_wr |-> $past(ctl.ip_rd))
      else $error("ip bin written without a read");

   a_load_to_eval: assert property (@(posedge clock) disable iff (reset)
      ctl.load_item |=> ctl.eval)
      else $error("accepted item not evaluated");
`endif

endmodule

// ===== rtl/pc_sample_histogram_profiler.sv =====
// PC sampling profiler.
// req channel: valid/ready; command selects sample, mark or read (code 3 is a
// no-op). Each accepted item yields exactly one rsp item holding the running
// pc/ip min and max and, for a read, the addressed bin (zero otherwise).
// csr_write_enable/csr_write_data load code_base; write only while idle.
// Items are handled one at a time. An accepted item passes EVAL, then by
// command: an in-window sample PC_RD and PC_WR, plus IP_RD and IP_WR when
// the ip bin is also counted; an out-of-window sample PC_RD; a mark
// MARK_WR; a read BIN_RD; a no-op nothing more; and last FINISH, which
// registers the result once the output register is free. The next item is
// taken in the cycle after the result is registered; the separate read and
// write states come from the read-modify-write of each single-port
// histogram memory. A stalled rsp holds in its output register; one
// further item is accepted and processed meanwhile, and its result waits
// until the pending one is taken. After reset the three stores are swept
// to zero, one entry per cycle through all WINDOW_SIZE entries; req_ready
// stays low during that pass while csr writes are taken as usual.
module pc_sample_histogram_profiler #(
   parameter int WINDOW_SIZE = pshp_pkg::WINDOW_SIZE_DEF,
   parameter int COUNT_BITS  = pshp_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pshp_pkg::CMD_W-1:0]  req_command,
   input  logic [pshp_pkg::ADDR_W-1:0] req_sample_pc,
   input  logic [pshp_pkg::ADDR_W-1:0] req_sample_ip,
   input  logic [pshp_pkg::ADDR_W-1:0] req_mark_address,
   input  logic [pshp_pkg::RIDX_W-1:0] req_read_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pshp_pkg::ADDR_W-1:0] rsp_pc_low,
   output logic [pshp_pkg::ADDR_W-1:0] rsp_pc_high,
   output logic [pshp_pkg::ADDR_W-1:0] rsp_ip_low,
   output logic [pshp_pkg::ADDR_W-1:0] rsp_ip_high,
   output logic [pshp_pkg::BIN_W-1:0]  rsp_bin_pc_count,
   output logic [pshp_pkg::BIN_W-1:0]  rsp_bin_ip_count,
   output logic                        rsp_bin_marked,
   input  logic                        csr_write_enable,
   input  logic [pshp_pkg::ADDR_W-1:0] csr_write_data
);
   import pshp_pkg::*;

   ctl_type ctl;
   sts_type sts;

   pshp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   pshp_datapath #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_command      (req_command),
      .req_sample_pc    (req_sample_pc),
      .req_sample_ip    (req_sample_ip),
      .req_mark_address (req_mark_address),
      .req_read_index   (req_read_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_pc_low       (rsp_pc_low),
      .rsp_pc_high      (rsp_pc_high),
      .rsp_ip_low       (rsp_ip_low),
      .rsp_ip_high      (rsp_ip_high),
      .rsp_bin_pc_count (rsp_bin_pc_count),
      .rsp_bin_ip_count (rsp_bin_ip_count),
      .rsp_bin_marked   (rsp_bin_marked)
   );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   import pshp_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
   localparam int               WINDOW  = WINDOW_SIZE_DEF;
   localparam logic [63:0]      ALL_ONES = '1;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] ip;
      logic [ADDR_W-1:0] mark;
      logic [RIDX_W-1:0] ridx;
   } profile_req_type;

   typedef struct {
      logic [ADDR_W-1:0] pc_low;
      logic [ADDR_W-1:0] pc_high;
      logic [ADDR_W-1:0] ip_low;
      logic [ADDR_W-1:0] ip_high;
      logic [BIN_W-1:0]  pc_bin;
      logic [BIN_W-1:0]  ip_bin;
      logic              marked;
   } profile_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command = CMD_NOP;
   logic [ADDR_W-1:0] req_sample_pc = '0;
   logic [ADDR_W-1:0] req_sample_ip = '0;
   logic [ADDR_W-1:0] req_mark_address = '0;
   logic [RIDX_W-1:0] req_read_index = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_pc_low;
   logic [ADDR_W-1:0] rsp_pc_high;
   logic [ADDR_W-1:0] rsp_ip_low;
   logic [ADDR_W-1:0] rsp_ip_high;
   logic [BIN_W-1:0]  rsp_bin_pc_count;
   logic [BIN_W-1:0]  rsp_bin_ip_count;
   logic              rsp_bin_marked;
   logic              csr_write_enable = 1'b0;
   logic [ADDR_W-1:0] csr_write_data = '0;

   // profiler image kept by the testbench
   logic [ADDR_W-1:0] base_addr;
   logic [BIN_W-1:0]  pc_hits [WINDOW];
   logic [BIN_W-1:0]  ip_hits [WINDOW];
   logic              dispatch_flag [WINDOW];
   logic [ADDR_W-1:0] pc_floor, pc_ceiling, ip_floor, ip_ceiling;

   profile_rsp_type expected_rsp_q [$];
   int              error_count = 0;
   int              idle_odds = 4;   // 0 turns idling off on both sides

   pc_sample_histogram_profiler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_sample_pc    (req_sample_pc),
      .req_sample_ip    (req_sample_ip),
      .req_mark_address (req_mark_address),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pc_low       (rsp_pc_low),
      .rsp_pc_high      (rsp_pc_high),
      .rsp_ip_low       (rsp_ip_low),
      .rsp_ip_high      (rsp_ip_high),
      .rsp_bin_pc_count (rsp_bin_pc_count),
      .rsp_bin_ip_count (rsp_bin_ip_count),
      .rsp_bin_marked   (rsp_bin_marked),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic in_window(logic [63:0] addr);
      logic [63:0] delta;
      delta = addr - base_addr;
      return (addr >= base_addr) && (delta < 64'(WINDOW));
   endfunction

   function automatic logic [BIN_W-1:0] saturating_inc(logic [BIN_W-1:0] cnt);
      return (cnt == '1) ? cnt : cnt + 1'b1;
   endfunction

   function automatic void clear_profile_image();
      base_addr  = '0;
      pc_floor   = '1;
      pc_ceiling = '0;
      ip_floor   = '1;
      ip_ceiling = '0;
      for (int i = 0; i < WINDOW; i++) begin
         pc_hits[i]       = '0;
         ip_hits[i]       = '0;
         dispatch_flag[i] = 1'b0;
      end
   endfunction

   // Apply one item to the image and return the result it must produce.
   function automatic profile_rsp_type profile_step(profile_req_type it);
      profile_rsp_type r;
      logic [63:0]     pc_off, ip_off, mk_off;
      r.pc_bin = '0;
      r.ip_bin = '0;
      r.marked = 1'b0;
      pc_off = it.pc - base_addr;
      ip_off = it.ip - base_addr;
      mk_off = it.mark - base_addr;
      case (it.command)
         CMD_SAMPLE: begin
            if (it.pc < pc_floor)   pc_floor   = it.pc;
            if (it.pc > pc_ceiling) pc_ceiling = it.pc;
            if (it.ip < ip_floor)   ip_floor   = it.ip;
            if (it.ip > ip_ceiling) ip_ceiling = it.ip;
            if (in_window(it.pc)) begin
               pc_hits[pc_off[RIDX_W-1:0]] = saturating_inc(pc_hits[pc_off[RIDX_W-1:0]]);
               if (dispatch_flag[pc_off[RIDX_W-1:0]] && it.ip > base_addr
                   && in_window(it.ip))
                  ip_hits[ip_off[RIDX_W-1:0]] = saturating_inc(ip_hits[ip_off[RIDX_W-1:0]]);
            end
         end
         CMD_MARK: begin
            if (in_window(it.mark)) dispatch_flag[mk_off[RIDX_W-1:0]] = 1'b1;
         end
         CMD_READ: begin
            if (32'(it.ridx) < WINDOW) begin
               r.pc_bin = pc_hits[it.ridx];
               r.ip_bin = ip_hits[it.ridx];
               r.marked = dispatch_flag[it.ridx];
            end
         end
         default: ;
      endcase
      r.pc_low  = pc_floor;
      r.pc_high = pc_ceiling;
      r.ip_low  = ip_floor;
      r.ip_high = ip_ceiling;
      return r;
   endfunction

   function automatic profile_req_type make_req(logic [CMD_W-1:0] cmd, logic [63:0] pc,
                                                logic [63:0] ip, logic [63:0] mark,
                                                logic [RIDX_W-1:0] ridx);
      profile_req_type it;
      it.command = cmd;
      it.pc      = pc;
      it.ip      = ip;
      it.mark    = mark;
      it.ridx    = ridx;
      return it;
   endfunction

   function automatic logic [63:0] hot_offset();
      if ($urandom_range(0, 4) != 0) return 64'($urandom_range(0, 31));
      return 64'($urandom_range(0, WINDOW - 1));
   endfunction

   // Mostly well-formed traffic around a small hot region of the window.
   function automatic profile_req_type make_profile_req();
      profile_req_type it;
      int              pick;
      it   = make_req(CMD_SAMPLE, rand64(), rand64(), rand64(), RIDX_W'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         it.command = CMD_SAMPLE;
         if ($urandom_range(0, 9) != 0) it.pc = base_addr + hot_offset();
         case ($urandom_range(0, 9))
            0:       it.ip = base_addr;
            1:       it.ip = rand64();
            default: it.ip = base_addr + 64'($urandom_range(1, 40));
         endcase
      end else if (pick < 74) begin
         it.command = CMD_MARK;
         if ($urandom_range(0, 5) != 0) it.mark = base_addr + hot_offset();
      end else if (pick < 95) begin
         it.command = CMD_READ;
         if ($urandom_range(0, 3) != 0) it.ridx = RIDX_W'(hot_offset());
      end else begin
         it.command = CMD_NOP;
      end
      return it;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: MISMATCH %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(profile_req_type it);
      int gap;
      gap = 0;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= it.command;
      req_sample_pc    <= it.pc;
      req_sample_ip    <= it.ip;
      req_mark_address <= it.mark;
      req_read_index   <= it.ridx;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(profile_step(it));
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_code_base(logic [63:0] value);
      wait_all_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      base_addr = value;
   endtask

   always @(posedge clock) begin : check_rsp
      profile_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_pc_low, '0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_pc_low !== want.pc_low)
               report_mismatch("pc_low", rsp_pc_low, want.pc_low);
            if (rsp_pc_high !== want.pc_high)
               report_mismatch("pc_high", rsp_pc_high, want.pc_high);
            if (rsp_ip_low !== want.ip_low)
               report_mismatch("ip_low", rsp_ip_low, want.ip_low);
            if (rsp_ip_high !== want.ip_high)
               report_mismatch("ip_high", rsp_ip_high, want.ip_high);
            if (rsp_bin_pc_count !== want.pc_bin)
               report_mismatch("bin_pc_count", 64'(rsp_bin_pc_count), 64'(want.pc_bin));
            if (rsp_bin_ip_count !== want.ip_bin)
               report_mismatch("bin_ip_count", 64'(rsp_bin_ip_count), 64'(want.ip_bin));
            if (rsp_bin_marked !== want.marked)
               report_mismatch("bin_marked", 64'(rsp_bin_marked), 64'(want.marked));
         end
      end
   end

   // Receiver back-pressure in short bursts.
   initial begin
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Window edges, dispatch marking and the ip rules at one fixed base.
   task automatic test_window_edges();
      logic [63:0] b;
      b = 64'h0000_0000_4000_1000;
      write_code_base(b);
      send_item(make_req(CMD_READ, rand64(), rand64(), rand64(), '0));
      send_item(make_req(CMD_SAMPLE, b, b + 5, rand64(), '1));
      send_item(make_req(CMD_MARK, rand64(), rand64(), b, '0));
      send_item(make_req(CMD_MARK, rand64(), rand64(), b - 1, '0));
      send_item(make_req(CMD_MARK, rand64(), rand64(), b + WINDOW, '0));
      send_item(make_req(CMD_MARK, rand64(), rand64(), b + WINDOW - 1, '0));
      // ip equal to base must not count, ip just above must
      send_item(make_req(CMD_SAMPLE, b, b, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, b, b + 1, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, b, b + WINDOW, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, b + WINDOW - 1, b + WINDOW - 1, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, b - 1, b + 2, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, b + WINDOW, b + 3, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, '0, '0, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, ALL_ONES, ALL_ONES, rand64(), '0));
      send_item(make_req(CMD_READ, rand64(), rand64(), rand64(), '0));
      send_item(make_req(CMD_READ, rand64(), rand64(), rand64(), 14'd1));
      send_item(make_req(CMD_READ, rand64(), rand64(), rand64(), '1));
      send_item(make_req(CMD_NOP, rand64(), rand64(), rand64(), RIDX_W'($urandom)));
   endtask

   // Base at the very bottom and the very top of the address space.
   task automatic test_base_extremes();
      logic [63:0] top_base;
      top_base = ALL_ONES - 64'(WINDOW - 1);
      write_code_base(ALL_ONES);
      send_item(make_req(CMD_MARK, rand64(), rand64(), ALL_ONES, '0));
      send_item(make_req(CMD_SAMPLE, ALL_ONES, ALL_ONES, rand64(), '0));
      send_item(make_req(CMD_READ, rand64(), rand64(), rand64(), '0));
      write_code_base(top_base);
      send_item(make_req(CMD_MARK, rand64(), rand64(), ALL_ONES, '0));
      send_item(make_req(CMD_SAMPLE, ALL_ONES, ALL_ONES, rand64(), '0));
      send_item(make_req(CMD_READ, rand64(), rand64(), rand64(), '1));
      write_code_base('0);
      send_item(make_req(CMD_MARK, rand64(), rand64(), '0, '0));
      send_item(make_req(CMD_SAMPLE, '0, '0, rand64(), '0));
      send_item(make_req(CMD_SAMPLE, '0, 64'd1, rand64(), '0));
      send_item(make_req(CMD_READ, rand64(), rand64(), rand64(), 14'd1));
   endtask

   // Several bases and idling levels, one of them with no idling at all.
   task automatic test_random_profile();
      logic [63:0] bases [5];
      int          odds [5];
      bases = '{64'h0, rand64(), ALL_ONES - 64'(WINDOW - 1), 64'($urandom), rand64()};
      odds  = '{3, 8, 0, 4, 12};
      for (int p = 0; p < 5; p++) begin
         write_code_base(bases[p]);
         idle_odds = odds[p];
         for (int n = 0; n < 300; n++) begin
            // hold off once per phase until the block has drained
            if (n == 150) wait_all_results();
            send_item(make_profile_req());
         end
      end
   endtask

   // Unshaped items with every field drawn at random.
   task automatic test_random_noise();
      write_code_base(rand64());
      idle_odds = 5;
      for (int n = 0; n < 300; n++)
         send_item(make_req(CMD_W'($urandom), rand64(), rand64(), rand64(),
                            RIDX_W'($urandom)));
   endtask

   // Full rate on both sides to close the run.
   task automatic test_back_to_back();
      write_code_base(64'($urandom_range(0, 255)));
      idle_odds = 0;
      for (int n = 0; n < 150; n++) send_item(make_profile_req());
   endtask

   initial begin
      clear_profile_image();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_window_edges();
      test_base_extremes();
      test_random_profile();
      test_random_noise();
      test_back_to_back();
      wait_all_results();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
